// ----- src/pidis_pkg.sv -----
// Shared types and constants for the PID controller with integral shaping.
// Holds the word structs, register indexes, controller states and the
// command/status structs that join controller and datapath.
package pidis_pkg;

    typedef struct packed {
        logic signed [31:0] target_value;
        logic signed [31:0] measured_value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] control_output;
        logic signed [31:0] integral_value;
    } result_t;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN        = 3'd0,
        REG_INTEG_GAIN       = 3'd1,
        REG_DERIV_GAIN       = 3'd2,
        REG_FEEDFORWARD_GAIN = 3'd3,
        REG_INTEGRAL_LIMIT   = 3'd4,
        REG_OUTPUT_LIMIT     = 3'd5,
        REG_DEAD_BAND        = 3'd6,
        REG_SEP_THRESHOLD    = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain;
        logic signed [31:0] deriv_gain_per_period;
        logic signed [31:0] feedforward_gain;
        logic [30:0]        integral_limit;
        logic [30:0]        output_limit;
        logic [30:0]        dead_band;
        logic [30:0]        separation_threshold;
    } cfg_t;

    localparam logic [16:0] ONE_Q16 = 17'h1_0000;

    localparam int PROD_W = 65;
    localparam int ACC_W  = 51;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRONT,
        ST_ZONE,
        ST_PREP,
        ST_RECIP,
        ST_QEST,
        ST_QFIX,
        ST_MUL_RP,
        ST_MUL_IE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_MUL_F,
        ST_ACC_F,
        ST_DONE
    } state_e;

    typedef enum logic [2:0] {
        MS_RATIO,
        MS_INTEG_STEP,
        MS_PROP,
        MS_INTEG,
        MS_DERIV,
        MS_FEED,
        MS_RECIP,
        MS_QEST
    } mul_sel_e;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_e;

    typedef struct packed {
        logic     load_in;
        logic     front;
        logic     zone;
        logic     prep;
        logic     q_load;
        logic     q_fix;
        mul_sel_e mul_sel;
        logic     integ_upd;
        acc_op_e  acc_op;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_blocked;
    } dp_stat_t;

endpackage

// ----- src/pidis_cfg.sv -----
// Configuration register file for the PID controller.
// Depends on pidis_pkg for cfg_t and the register index codes.
module pidis_cfg
    import pidis_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_PROP_GAIN:        cfg_next.prop_gain             = cfg_data;
                REG_INTEG_GAIN:       cfg_next.integ_gain            = cfg_data;
                REG_DERIV_GAIN:       cfg_next.deriv_gain_per_period = cfg_data;
                REG_FEEDFORWARD_GAIN: cfg_next.feedforward_gain      = cfg_data;
                REG_INTEGRAL_LIMIT:   cfg_next.integral_limit        = cfg_data[30:0];
                REG_OUTPUT_LIMIT:     cfg_next.output_limit          = cfg_data[30:0];
                REG_DEAD_BAND:        cfg_next.dead_band             = cfg_data[30:0];
                REG_SEP_THRESHOLD:    cfg_next.separation_threshold  = cfg_data[30:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/pidis_ctrl.sv -----
// Sequencer for the PID controller: steps one word through front end,
// ratio reciprocal divide, shared multiplier and output register. Uses pidis_pkg.
module pidis_ctrl
    import pidis_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_e state_reg;
    state_e state_next;

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (item_valid) state_next = ST_FRONT;
            ST_FRONT:  state_next = ST_ZONE;
            ST_ZONE:   state_next = ST_PREP;
            ST_PREP:   state_next = stat.need_div ? ST_RECIP : ST_MUL_RP;
            ST_RECIP:  state_next = ST_QEST;
            ST_QEST:   state_next = ST_QFIX;
            ST_QFIX:   state_next = ST_MUL_RP;
            ST_MUL_RP: state_next = ST_MUL_IE;
            ST_MUL_IE: state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_I;
            ST_MUL_I:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_MUL_F;
            ST_MUL_F:  state_next = ST_ACC_F;
            ST_ACC_F:  state_next = ST_DONE;
            ST_DONE:   if (!stat.out_blocked) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = MS_PROP;
        cmd.acc_op    = ACC_HOLD;
        unique case (state_reg)
            ST_IDLE:   cmd.load_in = item_valid;
            ST_FRONT:  cmd.front = 1'b1;
            ST_ZONE:   cmd.zone = 1'b1;
            ST_PREP:   cmd.prep = 1'b1;
            ST_RECIP:  cmd.mul_sel = MS_RECIP;
            ST_QEST:
            begin
                cmd.mul_sel = MS_QEST;
                cmd.q_load  = 1'b1;
            end
            ST_QFIX:   cmd.q_fix = 1'b1;
            ST_MUL_RP: cmd.mul_sel = MS_RATIO;
            ST_MUL_IE: cmd.mul_sel = MS_INTEG_STEP;
            ST_MUL_P:
            begin
                cmd.mul_sel   = MS_PROP;
                cmd.integ_upd = 1'b1;
            end
            ST_MUL_I:
            begin
                cmd.mul_sel = MS_INTEG;
                cmd.acc_op  = ACC_LOAD;
            end
            ST_MUL_D:
            begin
                cmd.mul_sel = MS_DERIV;
                cmd.acc_op  = ACC_ADD;
            end
            ST_MUL_F:
            begin
                cmd.mul_sel = MS_FEED;
                cmd.acc_op  = ACC_ADD;
            end
            ST_ACC_F:  cmd.acc_op = ACC_ADD;
            ST_DONE:   cmd.load_out = !stat.out_blocked;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/pidis_dp.sv -----
// Datapath of the PID controller: front end, dead zone, ratio reciprocal divide,
// shared 32x33 multiplier, term accumulator, loop state and result register.
// Uses pidis_pkg; driven by pidis_ctrl.
module pidis_dp
    import pidis_pkg::*;
#(
    parameter int PERIOD_Q16           = 66,
    parameter int VAR_SPEED_INNER      = 0,
    parameter int VAR_SPEED_OUTER      = 0,
    parameter int DERIV_ON_MEASUREMENT = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    input  item_t    item,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result
);

    localparam logic signed [32:0] PERIOD_OP = 33'(PERIOD_Q16);
    localparam logic [32:0] INNER = 33'(VAR_SPEED_INNER);
    localparam logic [32:0] OUTER = 33'(VAR_SPEED_OUTER);
    // ratio = floor(N * 2^16 / D) with N < D: estimate by N * floor(2^(s+16) / D) >> s,
    // s = clog2(D), which is at most one low, then one compare fixes it
    localparam bit DIV_USED = (VAR_SPEED_OUTER > VAR_SPEED_INNER);
    localparam longint DIV_DEN_L = DIV_USED
                                 ? longint'(VAR_SPEED_OUTER - VAR_SPEED_INNER) : 64'sd1;
    localparam int DIV_SHIFT = $clog2(DIV_DEN_L);
    localparam longint RECIP_L = (64'sd1 <<< (DIV_SHIFT + 16)) / DIV_DEN_L;
    localparam logic signed [32:0] RECIP_OP = 33'(RECIP_L);
    localparam logic signed [32:0] DEN_OP = 33'(DIV_DEN_L);
    localparam logic [47:0] DEN_CMP = 48'(DIV_DEN_L);
    localparam bit SPEED_FIXED = (VAR_SPEED_INNER == 0) && (VAR_SPEED_OUTER == 0);
    localparam bit D_ON_MEAS = (DERIV_ON_MEASUREMENT != 0);
    localparam logic signed [ACC_W-1:0] ACC_MAX32 = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] ACC_MIN32 = ~ACC_MAX32;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (!v[33] && (v[32:31] != 2'b00))
            r = 32'h7FFF_FFFF;
        else if (v[33] && (v[32:31] != 2'b11))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // word in flight
    logic signed [31:0]       tgt_reg, tgt_next;
    logic signed [31:0]       meas_reg, meas_next;
    logic signed [32:0]       raw_reg, raw_next;
    logic [32:0]              mag_reg, mag_next;
    logic signed [31:0]       err_reg, err_next;
    logic signed [31:0]       eff_tgt_reg, eff_tgt_next;
    logic signed [31:0]       integ_reg, integ_next;
    logic                     sep_reg, sep_next;
    logic signed [32:0]       d_opnd_reg, d_opnd_next;
    logic signed [32:0]       f_opnd_reg, f_opnd_next;
    logic [16:0]              ratio_reg, ratio_next;
    logic [31:0]              num_reg, num_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    result_t                  result_reg, result_next;
    logic                     result_valid_reg, result_valid_next;

    // loop state
    logic signed [31:0] integ_acc_reg, integ_acc_next;
    logic signed [31:0] last_err_reg, last_err_next;
    logic signed [31:0] last_meas_reg, last_meas_next;
    logic signed [31:0] last_tgt_reg, last_tgt_next;

    logic                     ratio_one;
    logic signed [31:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [48:0]       term;
    logic signed [32:0]       integ_incr;
    logic signed [32:0]       ilim;
    logic signed [32:0]       acc_old;
    logic signed [33:0]       err_wide;
    logic [15:0]              q_est;
    logic [47:0]              q_rem;
    logic signed [ACC_W-1:0]  olim;
    logic signed [ACC_W-1:0]  out_hi;
    logic signed [ACC_W-1:0]  out_lo;
    logic signed [31:0]       out_val;

    assign ratio_one = SPEED_FIXED || (mag_reg <= INNER);
    assign stat.need_div = !ratio_one && (mag_reg < OUTER);
    assign stat.out_blocked = result_valid_reg && result_stall;

    assign result_valid = result_valid_reg;
    assign result = result_reg;

    // floor of the product over 2^16
    assign term = prod_reg[PROD_W-1:16];
    assign integ_incr = prod_reg[48:16];

    assign ilim = $signed({2'b00, cfg.integral_limit});
    assign acc_old = {integ_acc_reg[31], integ_acc_reg};
    assign err_wide = raw_reg[32]
                    ? ({raw_reg[32], raw_reg} + {3'b000, cfg.dead_band})
                    : ({raw_reg[32], raw_reg} - {3'b000, cfg.dead_band});
    assign q_est = 16'(prod_reg >> DIV_SHIFT);
    assign q_rem = {num_reg, 16'h0000} - prod_reg[47:0];

    assign olim = $signed({{(ACC_W-31){1'b0}}, cfg.output_limit});
    assign out_hi = (cfg.output_limit != '0) ? olim : ACC_MAX32;
    assign out_lo = (cfg.output_limit != '0) ? -olim : ACC_MIN32;

    always_comb
    begin
        if (acc_reg > out_hi)
            out_val = out_hi[31:0];
        else if (acc_reg < out_lo)
            out_val = out_lo[31:0];
        else
            out_val = acc_reg[31:0];
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_RATIO:
            begin
                mul_a = $signed({15'b0, ratio_reg});
                mul_b = PERIOD_OP;
            end
            MS_INTEG_STEP:
            begin
                mul_a = $signed({15'b0, prod_reg[32:16]});
                mul_b = {err_reg[31], err_reg};
            end
            MS_PROP:
            begin
                mul_a = cfg.prop_gain;
                mul_b = {err_reg[31], err_reg};
            end
            MS_INTEG:
            begin
                mul_a = cfg.integ_gain;
                mul_b = {integ_reg[31], integ_reg};
            end
            MS_DERIV:
            begin
                mul_a = cfg.deriv_gain_per_period;
                mul_b = d_opnd_reg;
            end
            MS_FEED:
            begin
                mul_a = cfg.feedforward_gain;
                mul_b = f_opnd_reg;
            end
            MS_RECIP:
            begin
                mul_a = $signed(num_reg);
                mul_b = RECIP_OP;
            end
            MS_QEST:
            begin
                mul_a = $signed({16'b0, q_est});
                mul_b = DEN_OP;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        tgt_next          = tgt_reg;
        meas_next         = meas_reg;
        raw_next          = raw_reg;
        mag_next          = mag_reg;
        err_next          = err_reg;
        eff_tgt_next      = eff_tgt_reg;
        integ_next        = integ_reg;
        sep_next          = sep_reg;
        d_opnd_next       = d_opnd_reg;
        f_opnd_next       = f_opnd_reg;
        ratio_next        = ratio_reg;
        num_next          = num_reg;
        acc_next          = acc_reg;
        result_next       = result_reg;
        integ_acc_next    = integ_acc_reg;
        last_err_next     = last_err_reg;
        last_meas_next    = last_meas_reg;
        last_tgt_next     = last_tgt_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (cmd.load_in)
        begin
            tgt_next  = item.target_value;
            meas_next = item.measured_value;
        end

        if (cmd.front)
        begin
            raw_next = {tgt_reg[31], tgt_reg} - {meas_reg[31], meas_reg};
            // both differences in parallel, the sign picks the magnitude
            if (raw_next[32])
                mag_next = {meas_reg[31], meas_reg} - {tgt_reg[31], tgt_reg};
            else
                mag_next = raw_next;
            if ((cfg.integral_limit != '0) && (acc_old > ilim))
                integ_next = ilim[31:0];
            else if ((cfg.integral_limit != '0) && (acc_old < -ilim))
                integ_next = 32'(-ilim);
            else
                integ_next = integ_acc_reg;
        end

        if (cmd.zone)
        begin
            if (mag_reg <= {2'b00, cfg.dead_band})
            begin
                err_next     = '0;
                eff_tgt_next = meas_reg;
                mag_next     = '0;
            end
            else
            begin
                err_next     = sat34(err_wide);
                eff_tgt_next = tgt_reg;
            end
        end

        if (cmd.prep)
        begin
            if (D_ON_MEAS)
                d_opnd_next = {last_meas_reg[31], last_meas_reg} - {meas_reg[31], meas_reg};
            else
                d_opnd_next = {err_reg[31], err_reg} - {last_err_reg[31], last_err_reg};
            f_opnd_next = {eff_tgt_reg[31], eff_tgt_reg} - {last_tgt_reg[31], last_tgt_reg};
            sep_next = (cfg.separation_threshold != '0)
                    && (mag_reg >= {2'b00, cfg.separation_threshold});
            ratio_next = ratio_one ? ONE_Q16 : '0;
            num_next = 32'(OUTER - mag_reg);
        end

        if (cmd.q_load)
            ratio_next = {1'b0, q_est};

        // estimate one low when the remainder still holds a whole divisor
        if (cmd.q_fix)
        begin
            if (q_rem >= DEN_CMP)
                ratio_next = ratio_reg + 17'd1;
        end

        if (cmd.integ_upd)
        begin
            if (sep_reg)
                integ_next = '0;
            else
                integ_next = sat34({{2{integ_reg[31]}}, integ_reg}
                                   + {integ_incr[32], integ_incr});
        end

        unique case (cmd.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_LOAD: acc_next = ACC_W'(term);
            ACC_ADD:  acc_next = acc_reg + ACC_W'(term);
            default:  acc_next = acc_reg;
        endcase

        if (cmd.load_out)
        begin
            result_next.control_output = out_val;
            result_next.integral_value = integ_reg;
            result_valid_next          = 1'b1;
            integ_acc_next             = integ_reg;
            last_err_next              = err_reg;
            last_meas_next             = meas_reg;
            last_tgt_next              = eff_tgt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg     <= tgt_next;
        meas_reg    <= meas_next;
        raw_reg     <= raw_next;
        mag_reg     <= mag_next;
        err_reg     <= err_next;
        eff_tgt_reg <= eff_tgt_next;
        integ_reg   <= integ_next;
        sep_reg     <= sep_next;
        d_opnd_reg  <= d_opnd_next;
        f_opnd_reg  <= f_opnd_next;
        ratio_reg   <= ratio_next;
        num_reg     <= num_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            integ_acc_reg    <= '0;
            last_err_reg     <= '0;
            last_meas_reg    <= '0;
            last_tgt_reg     <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            integ_acc_reg    <= integ_acc_next;
            last_err_reg     <= last_err_next;
            last_meas_reg    <= last_meas_next;
            last_tgt_reg     <= last_tgt_next;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(result_valid_reg && result_stall))
        else $error("result register overwritten while its word is held");

    a_sep_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.integ_upd && sep_reg) |=> (integ_reg == '0))
        else $error("integral not cleared under separation");

    a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_sel == MS_RATIO) |-> (ratio_reg <= ONE_Q16))
        else $error("speed ratio above one");

    a_out_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && (cfg.output_limit != '0)) |=>
        (($signed({result_reg.control_output[31], result_reg.control_output})
            <= $signed({2'b00, $past(cfg.output_limit)}))
        && ($signed({result_reg.control_output[31], result_reg.control_output})
            >= -$signed({2'b00, $past(cfg.output_limit)}))))
        else $error("control output beyond output limit");

endmodule

// ----- src/pid_controller_with_integral_shaping_unit.sv -----
// PID controller with dead zone, variable-speed clamped integral, integral
// separation, derivative on error or measurement and feedforward on target
// change, all in signed Q16.16. One word is worked on at a time: it passes
// front end, dead zone, operand preparation and the multiplier steps, and
// the result register loads in the done state; when the variable-speed
// magnitude falls strictly between the inner and outer bounds, a reciprocal
// multiply and a one-step correction of the ratio come in between. The single
// shared 32x33 multiplier forms the products of a tick in turn (six, eight
// with the ratio divide). The result register lets the next word be accepted
// while a result still waits. No clearing pass after reset.
// Depends on pidis_pkg, pidis_cfg, pidis_ctrl and pidis_dp.
module pid_controller_with_integral_shaping_unit
    import pidis_pkg::*;
#(
    parameter int PERIOD_Q16           = 66,
    parameter int VAR_SPEED_INNER      = 0,
    parameter int VAR_SPEED_OUTER      = 0,
    parameter int DERIV_ON_MEASUREMENT = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    pidis_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidis_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    pidis_dp #(
        .PERIOD_Q16           (PERIOD_Q16),
        .VAR_SPEED_INNER      (VAR_SPEED_INNER),
        .VAR_SPEED_OUTER      (VAR_SPEED_OUTER),
        .DERIV_ON_MEASUREMENT (DERIV_ON_MEASUREMENT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
